### design/mrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int FrameLen = 8;
  localparam int CrcSpan  = 6;
  localparam int PosW     = $clog2(FrameLen);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef logic [7:0] octet_t;

  // header bytes in transmission order, element 0 sent first
  typedef octet_t [CrcSpan-1:0] req_bytes_t;

  typedef enum logic [PosW-1:0] {
    FP_SLAVE    = 3'd0,
    FP_FUNC     = 3'd1,
    FP_START_HI = 3'd2,
    FP_START_LO = 3'd3,
    FP_COUNT_HI = 3'd4,
    FP_COUNT_LO = 3'd5,
    FP_CRC_LO   = 3'd6,
    FP_CRC_HI   = 3'd7
  } frame_pos_t;

  // one byte of CRC-16/MODBUS, reflected, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input octet_t data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/mrf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_if
// Valid/ready channels: request items in, frame byte items out.
// ----------------------------------------------------------------------------
interface mrf_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slave_id;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] register_count;

  modport source (output valid, slave_id, function_code, start_address, register_count,
                  input ready);
  modport sink   (input valid, slave_id, function_code, start_address, register_count,
                  output ready);
endinterface

interface mrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

### design/mrf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_front
// Input register stage: accepts a request and splits it into header bytes.
// ----------------------------------------------------------------------------
module mrf_front (
  input  logic                clk,
  input  logic                rst,
  mrf_req_if.sink             req,
  output logic                push_valid,
  output mrf_pkg::req_bytes_t push_data,
  input  logic                push_ready
);

  logic vld;
  mrf_pkg::req_bytes_t bytes;

  assign req.ready  = !vld || push_ready;
  assign push_valid = vld;
  assign push_data  = bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (req.ready) begin
      vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      bytes[0] <= req.slave_id;
      bytes[1] <= req.function_code;
      bytes[2] <= req.start_address[15:8];
      bytes[3] <= req.start_address[7:0];
      bytes[4] <= req.register_count[15:8];
      bytes[5] <= req.register_count[7:0];
    end
  end

endmodule

### design/mrf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_queue
// Two-entry request queue between the front stage and the serialiser.
// ----------------------------------------------------------------------------
module mrf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  mrf_pkg::req_bytes_t push_data,
  output logic                push_ready,
  output logic                pop_valid,
  output mrf_pkg::req_bytes_t pop_data,
  input  logic                pop_ready
);

  mrf_pkg::req_bytes_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### design/mrf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_back
// Serialiser: sends the six header bytes and the running CRC, one per cycle while rsp is ready.
// ----------------------------------------------------------------------------
module mrf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  mrf_pkg::req_bytes_t pop_data,
  output logic                pop_ready,
  mrf_byte_if.source          rsp
);

  logic                busy;
  mrf_pkg::frame_pos_t pos;
  mrf_pkg::req_bytes_t bytes;
  logic [15:0]         crc;
  mrf_pkg::octet_t     cur;
  logic                fire;
  logic                done;
  logic                load;

  always_comb begin
    unique case (pos)
      mrf_pkg::FP_SLAVE:    cur = bytes[0];
      mrf_pkg::FP_FUNC:     cur = bytes[1];
      mrf_pkg::FP_START_HI: cur = bytes[2];
      mrf_pkg::FP_START_LO: cur = bytes[3];
      mrf_pkg::FP_COUNT_HI: cur = bytes[4];
      mrf_pkg::FP_COUNT_LO: cur = bytes[5];
      mrf_pkg::FP_CRC_LO:   cur = crc[7:0];
      mrf_pkg::FP_CRC_HI:   cur = crc[15:8];
      default:              cur = crc[15:8];
    endcase
  end

  assign rsp.valid      = busy;
  assign rsp.frame_byte = cur;
  assign rsp.last_byte  = (pos == mrf_pkg::FP_CRC_HI);

  assign fire      = busy && rsp.ready;
  assign done      = fire && (pos == mrf_pkg::FP_CRC_HI);
  assign pop_ready = !busy || done;
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= mrf_pkg::FP_SLAVE;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= mrf_pkg::FP_SLAVE;
    end else if (done) begin
      busy <= 1'b0;
      pos  <= mrf_pkg::FP_SLAVE;
    end else if (fire) begin
      pos  <= mrf_pkg::frame_pos_t'(pos + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= pop_data;
      crc   <= mrf_pkg::CrcInit;
    end else if (fire && (pos < mrf_pkg::FP_CRC_LO)) begin
      crc   <= mrf_pkg::crc_update(crc, cur);
    end
  end

endmodule

### design/modbus_rtu_request_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_unit
// Modbus RTU request framer: one request in, eight frame bytes out with the
// CRC-16/MODBUS appended low byte first.
//
//   channel  dir  payload                                        per item
//   req      in   slave_id, function_code, start_address,        1 request
//                 register_count
//   rsp      out  frame_byte, last_byte                          1 byte
//
// Sustained rate is set by the serialiser sending one byte per cycle while rsp
// is ready; the CRC advances one byte per sent header byte.
// A request passes the front stage and a queue entry before its first byte appears.
// Up to four requests in flight: front stage, two queue entries, serialiser.
// Synchronous reset empties every stage; no clearing pass.
// A stall on rsp holds the current byte; req keeps being taken until full.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit (
  input  logic       clk,
  input  logic       rst,
  mrf_req_if.sink    req,
  mrf_byte_if.source rsp
);

  logic                push_valid;
  logic                push_ready;
  mrf_pkg::req_bytes_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  mrf_pkg::req_bytes_t pop_data;

  mrf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  mrf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  mrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

endmodule

### design/mrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_checker
// Port-level checks: frame length, outstanding requests, rsp handshake.
// ----------------------------------------------------------------------------
module mrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_frame_byte,
  input logic       rsp_last_byte
);

  logic [mrf_pkg::PosW-1:0] byte_cnt;
  logic [2:0]               pending;
  logic                     req_fire;
  logic                     frame_end;

  assign req_fire  = req_valid && req_ready;
  assign frame_end = rsp_valid && rsp_ready && rsp_last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
      pending  <= '0;
    end else begin
      if (rsp_valid && rsp_ready) byte_cnt <= byte_cnt + 1'b1;
      unique case ({req_fire, frame_end})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_last_on_eighth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_last_byte == (byte_cnt == (mrf_pkg::PosW)'(mrf_pkg::FrameLen - 1))))
    else $error("last_byte not on the eighth byte of a frame");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != 3'd0))
    else $error("frame byte with no request outstanding");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> ($stable(rsp_frame_byte) && $stable(rsp_last_byte)))
    else $error("rsp item changed while stalled");

endmodule

bind modbus_rtu_request_framer_unit mrf_checker u_mrf_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_frame_byte (rsp.frame_byte),
  .rsp_last_byte  (rsp.last_byte)
);
